### rtl/core/gapr_pkg.sv
`default_nettype none

package gapr_pkg;

    // Fixed widths of the ports.
    localparam int SAMPLE_W      = 8;
    localparam int AVERAGE_W     = 8;
    localparam int PIXEL_COUNT_W = 13;
    localparam int MULT_W        = 31;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 31;

    // Q7.24 requantization.
    localparam int FRAC_BITS = 24;

    // Saturation limits of the result.
    localparam int AVG_MAX = 127;
    localparam int AVG_MIN = -128;

    localparam int MAX_PIXELS_DEF = 4096;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIVIDE_MODE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_MULTIPLR = 2'd2;

    // Register values after reset.
    localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RST = 13'd1;
    localparam logic                     DIVIDE_MODE_RST = 1'b1;
    localparam logic [MULT_W-1:0]        MULT_RST        = 31'd16777216;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // a sample transaction completes this cycle
        logic mul;       // form the requantization product
        logic div_step;  // one restoring division step
        logic load_out;  // saturate and load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;         // the next sample completes the plane
        logic divide_mode;  // divide mode selected
    } status_t;

endpackage

`default_nettype wire

### rtl/core/gapr_ctrl.sv
`default_nettype none

module gapr_ctrl #(
    parameter int DIV_STEPS = 21
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            sample_valid,
    output logic                 sample_ready,
    output logic                 average_valid,
    input  wire logic            average_ready,
    input  wire gapr_pkg::status_t status,
    output gapr_pkg::cmd_t       cmd
);

    localparam int STEP_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        S_ACC,
        S_MUL,
        S_DIV,
        S_FIN
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                out_valid_reg;
    logic                accept;

    // The final sample of a plane waits until the previous average is gone.
    assign sample_ready  = (state_reg == S_ACC) && !(status.last && out_valid_reg);
    assign accept        = sample_valid && sample_ready;
    assign average_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.mul      = (state_reg == S_MUL);
        cmd.div_step = (state_reg == S_DIV);
        cmd.load_out = (state_reg == S_FIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (average_valid && average_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_ACC:
                begin
                    if (accept && status.last)
                    begin
                        step_reg  <= '0;
                        state_reg <= status.divide_mode ? S_DIV : S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_FIN;
                end
                S_DIV:
                begin
                    if (step_reg == STEP_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                    step_reg <= step_reg + STEP_W'(1);
                end
                S_FIN:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_ACC;
                end
                default:
                begin
                    state_reg <= S_ACC;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/gapr_dp.sv
`default_nettype none

module gapr_dp #(
    parameter int MAX_PIXELS = gapr_pkg::MAX_PIXELS_DEF,
    parameter int SUM_W      = 21,
    parameter int CNT_W      = 13,
    parameter int DIVD_W     = 21
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_we,
    input  wire logic [gapr_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [gapr_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire logic signed [gapr_pkg::SAMPLE_W-1:0]    sample,
    output logic signed [gapr_pkg::AVERAGE_W-1:0]        average,
    input  wire gapr_pkg::cmd_t                          cmd,
    output gapr_pkg::status_t                            status
);

    localparam int MAG_W  = SUM_W - 1;
    localparam int PROD_W = MAG_W + gapr_pkg::MULT_W;
    localparam int RND_W  = PROD_W + 1 - gapr_pkg::FRAC_BITS;
    localparam int SW     = gapr_pkg::SAMPLE_W;
    localparam int AW     = gapr_pkg::AVERAGE_W;

    // Configuration registers.
    logic [gapr_pkg::PIXEL_COUNT_W-1:0] pixel_count_reg;
    logic                               divide_mode_reg;
    logic [gapr_pkg::MULT_W-1:0]        mult_reg;

    // Plane accumulation.
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0]        seen_reg;
    logic [CNT_W-1:0]        n_eff;

    // Per-plane result computation.
    logic                neg_reg;
    logic [MAG_W-1:0]    mag_reg;
    logic [MAG_W-1:0]    mag_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [CNT_W-1:0]    div_reg;
    logic [DIVD_W-1:0]   quo_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W:0]      trial;
    logic                trial_ge;
    logic [PROD_W:0]     rnd_sum;
    logic [RND_W-1:0]    q_sel;
    logic                ge_min;
    logic                ge_max;
    logic [AW-1:0]       avg_next;
    logic signed [AW-1:0] avg_reg;

    // A count of zero acts as one, a count above the maximum as the maximum.
    always_comb
    begin
        if (pixel_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (32'(pixel_count_reg) > 32'(MAX_PIXELS))
        begin
            n_eff = CNT_W'(MAX_PIXELS);
        end
        else
        begin
            n_eff = CNT_W'(pixel_count_reg);
        end
    end

    assign status.last        = ({1'b0, seen_reg} + (CNT_W + 1)'(1)) >= {1'b0, n_eff};
    assign status.divide_mode = divide_mode_reg;

    assign sum_next = sum_reg + {{(SUM_W - SW){sample[SW-1]}}, sample};
    assign mag_next = sum_next[SUM_W-1] ? MAG_W'(-sum_next) : MAG_W'(sum_next);

    // Restoring division, one quotient bit per step.
    assign trial    = {rem_reg, quo_reg[DIVD_W-1]};
    assign trial_ge = trial >= {1'b0, div_reg};

    // Multiply mode rounds half up on the magnitude, then drops the fraction.
    assign rnd_sum = {1'b0, prod_reg}
                   + ((PROD_W + 1)'(1) << (gapr_pkg::FRAC_BITS - 1));
    assign q_sel   = divide_mode_reg ? RND_W'(quo_reg)
                                     : rnd_sum[PROD_W:gapr_pkg::FRAC_BITS];

    assign ge_min = q_sel >= RND_W'(-gapr_pkg::AVG_MIN);
    assign ge_max = q_sel >= RND_W'(gapr_pkg::AVG_MAX);

    always_comb
    begin
        if (neg_reg)
        begin
            avg_next = ge_min ? AW'(gapr_pkg::AVG_MIN) : AW'(-q_sel[AW-1:0]);
        end
        else
        begin
            avg_next = ge_max ? AW'(gapr_pkg::AVG_MAX) : q_sel[AW-1:0];
        end
    end

    assign average = avg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg <= gapr_pkg::PIXEL_COUNT_RST;
            divide_mode_reg <= gapr_pkg::DIVIDE_MODE_RST;
            mult_reg        <= gapr_pkg::MULT_RST;
            sum_reg         <= '0;
            seen_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gapr_pkg::CFG_PIXEL_COUNT:
                    begin
                        pixel_count_reg <= cfg_data[gapr_pkg::PIXEL_COUNT_W-1:0];
                    end
                    gapr_pkg::CFG_DIVIDE_MODE:
                    begin
                        divide_mode_reg <= cfg_data[0];
                    end
                    gapr_pkg::CFG_SCALE_MULTIPLR:
                    begin
                        mult_reg <= cfg_data[gapr_pkg::MULT_W-1:0];
                    end
                    default:
                    begin
                        pixel_count_reg <= pixel_count_reg;
                    end
                endcase
            end
            if (cmd.accept)
            begin
                if (status.last)
                begin
                    sum_reg  <= '0;
                    seen_reg <= '0;
                end
                else
                begin
                    sum_reg  <= sum_next;
                    seen_reg <= seen_reg + CNT_W'(1);
                end
            end
        end
    end

    // Payload registers of the result path.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.last)
        begin
            neg_reg <= sum_next[SUM_W-1];
            mag_reg <= mag_next;
            div_reg <= n_eff;
            quo_reg <= DIVD_W'(mag_next) + DIVD_W'(n_eff >> 1);
            rem_reg <= '0;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(mult_reg);
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? CNT_W'(trial - {1'b0, div_reg}) : CNT_W'(trial);
            quo_reg <= {quo_reg[DIVD_W-2:0], trial_ge};
        end
        if (cmd.load_out)
        begin
            avg_reg <= avg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/int8_global_avg_pool_requant.sv
// Channel   Direction  Signals                              Content
// sample    in         sample_valid, sample_ready, sample   one int8 pixel of a plane
// average   out        average_valid, average_ready, average one int8 average per plane
// config    in         cfg_we, cfg_index, cfg_data          register write, no wait
//
// A sample that does not end its plane is taken while the block accumulates. The sample
// that ends a plane starts the result: in multiply mode the product, then rounding and
// saturation; in divide mode the restoring divider, which retires one quotient bit per
// cycle, then saturation; no sample is taken until the result is loaded.
// Reset is asynchronous and active low; it clears the sum, count and output valid.
// The last sample of a plane is held while the previous average still waits.
`default_nettype none

module int8_global_avg_pool_requant #(
    parameter int MAX_PIXELS = gapr_pkg::MAX_PIXELS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [gapr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [gapr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 sample_valid,
    output logic                                      sample_ready,
    input  wire logic signed [gapr_pkg::SAMPLE_W-1:0] sample,
    output logic                                      average_valid,
    input  wire logic                                 average_ready,
    output logic signed [gapr_pkg::AVERAGE_W-1:0]     average
);

    // The sum of a full plane of int8 samples is held in log2 of the plane size
    // plus nine bits, signed. The divider takes the magnitude plus the
    // rounding half, one bit wider than the magnitude.
    localparam int SUM_W  = $clog2(MAX_PIXELS) + 9;
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int DIVD_W = SUM_W;

    gapr_pkg::cmd_t    cmd;
    gapr_pkg::status_t status;

    // The controller sequences accumulation, the multiply or divide, and
    // the output handshake.
    gapr_ctrl #(
        .DIV_STEPS (DIVD_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .average_valid (average_valid),
        .average_ready (average_ready),
        .status        (status),
        .cmd           (cmd)
    );

    // The datapath holds the registers, the running sum, the divider, the
    // multiplier and the output register.
    gapr_dp #(
        .MAX_PIXELS (MAX_PIXELS),
        .SUM_W      (SUM_W),
        .CNT_W      (CNT_W),
        .DIVD_W     (DIVD_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .average   (average),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire
